// ===== design/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg: shared types and codes of the bounded array list
// Request codes, status codes, cell shift codes and the cell control bundle.
// ----------------------------------------------------------------------------
package bal_pkg;

    // Port widths fixed by the item format
    localparam int REQ_W = 4;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    typedef logic [REQ_W-1:0]        req_t;
    typedef logic signed [VAL_W-1:0] word_t;
    typedef logic [ST_W-1:0]         status_t;
    typedef logic [1:0]              cell_op_t;

    // Request codes
    localparam req_t REQ_PUSH_FRONT = 4'd0;
    localparam req_t REQ_PUSH_BACK  = 4'd1;
    localparam req_t REQ_INSERT_AT  = 4'd2;
    localparam req_t REQ_POP_FRONT  = 4'd3;
    localparam req_t REQ_POP_BACK   = 4'd4;
    localparam req_t REQ_REMOVE_AT  = 4'd5;
    localparam req_t REQ_FIRST      = 4'd6;
    localparam req_t REQ_LAST       = 4'd7;
    localparam req_t REQ_READ_AT    = 4'd8;
    localparam req_t REQ_SEARCH     = 4'd9;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    // Cell moves
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_SHR  = 2'd1;
    localparam cell_op_t CELL_SHL  = 2'd2;

    // Control broadcast to every cell
    typedef struct packed {
        logic     exec;
        cell_op_t op;
        logic     srch;
        logic     rd;
    } bal_ctrl_t;

endpackage

// ===== design/bal_cell.sv =====
// ----------------------------------------------------------------------------
// bal_cell: one slot of the list
// Holds one entry, shifts it to or from its neighbors and flags a hit.
// ----------------------------------------------------------------------------
module bal_cell #(
    parameter int DEPTH = 16,
    parameter int INDEX = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bal_pkg::bal_ctrl_t                    ctrl,
    input  logic [$clog2(DEPTH)-1:0]              at_idx,
    input  logic [$clog2(DEPTH)-1:0]              rd_idx,
    input  logic [$clog2(DEPTH+1)-1:0]            count,
    input  bal_pkg::word_t                        value,
    input  bal_pkg::word_t                        left_entry,
    input  bal_pkg::word_t                        right_entry,
    output bal_pkg::word_t                        entry,
    output logic                                  tag
);
    import bal_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH+1);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);
    localparam logic [CNTW-1:0] MY_CNT = CNTW'(INDEX);

    word_t entry_reg, entry_next;
    logic  tag_reg, tag_next;

    // Pick the new entry and the hit flag
    always_comb begin
        entry_next = entry_reg;
        tag_next   = tag_reg;
        if (ctrl.exec) begin
            case (ctrl.op)
                CELL_SHR: begin
                    if (MY_IDX > at_idx) begin
                        entry_next = left_entry;
                    end else if (MY_IDX == at_idx) begin
                        entry_next = value;
                    end
                end
                CELL_SHL: begin
                    if (MY_IDX >= at_idx) begin
                        entry_next = right_entry;
                    end
                end
                default: ;
            endcase
            tag_next = (ctrl.srch && (MY_CNT < count) && (entry_reg == value)) ||
                       (ctrl.rd && (MY_IDX == rd_idx));
        end
    end

    // Hold the entry
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // Hold the hit flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= 1'b0;
        end else begin
            tag_reg <= tag_next;
        end
    end

    assign entry = entry_reg;
    assign tag   = tag_reg;

endmodule

// ===== design/bounded_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_unit: ordered list of signed words with insert and remove
// An accepted item passes the execute and finish states, then its result is
// held with m_valid until m_ready; no item is taken before that, as decode,
// cell update, hit collection and result stages run in series. Reset is
// synchronous: the count clears at a clock edge and the block is ready in the
// next cycle; entries keep no reset value and are never read before written.
// ----------------------------------------------------------------------------
module bounded_array_list_unit #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bal_pkg::REQ_W-1:0]      s_req_type,
    input  logic signed [bal_pkg::VAL_W-1:0] s_value,
    input  logic [bal_pkg::POS_W-1:0]      s_position,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bal_pkg::ST_W-1:0]       m_status,
    output logic signed [bal_pkg::VAL_W-1:0] m_read_value,
    output logic [bal_pkg::POS_W-1:0]      m_found_position,
    output logic [bal_pkg::CNT_W-1:0]      m_entry_count
);
    import bal_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH+1);
    localparam int CMPW = ((CNTW > POS_W) ? CNTW : POS_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    bal_ctrl_t       ctrl_reg, dec_ctrl, cell_ctrl;
    logic [IDXW-1:0] at_reg, dec_at;
    logic [IDXW-1:0] rd_reg, dec_rd;
    status_t         st_reg, dec_st;
    word_t           value_reg;

    status_t         m_status_reg;
    word_t           m_read_value_reg;
    logic [POS_W-1:0] m_found_position_reg;
    logic [CNT_W-1:0] m_entry_count_reg;

    logic            s_fire;
    logic [CMPW-1:0] cnt_ext, pos_ext, pos_m1;
    logic            full, empty, ins_ok, pos_ok;

    word_t           entry_w [DEPTH];
    word_t           left_w  [DEPTH];
    word_t           right_w [DEPTH];
    logic [DEPTH-1:0] tag_w;
    word_t           rd_or;
    logic [CNTW-1:0] found_w;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);
    assign s_fire  = s_valid && s_ready;

    // Decode the item against the current count
    always_comb begin
        cnt_ext    = CMPW'(count_reg);
        pos_ext    = CMPW'(s_position);
        pos_m1     = pos_ext - CMPW'(1);
        full       = (count_reg == CNTW'(DEPTH));
        empty      = (count_reg == '0);
        ins_ok     = (pos_ext >= CMPW'(1)) && (pos_ext <= cnt_ext + CMPW'(1));
        pos_ok     = (pos_ext >= CMPW'(1)) && (pos_ext <= cnt_ext);
        dec_st     = ST_OK;
        dec_ctrl   = '{exec: 1'b0, op: CELL_HOLD, srch: 1'b0, rd: 1'b0};
        dec_at     = '0;
        dec_rd     = '0;
        count_next = count_reg;
        unique case (s_req_type) inside
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_AT: begin
                if (full) begin
                    dec_st = ST_FULL;
                end else if ((s_req_type == REQ_INSERT_AT) && !ins_ok) begin
                    dec_st = ST_RANGE;
                end else begin
                    dec_ctrl.op = CELL_SHR;
                    count_next  = count_reg + CNTW'(1);
                    if (s_req_type == REQ_PUSH_BACK) begin
                        dec_at = IDXW'(count_reg);
                    end else if (s_req_type == REQ_INSERT_AT) begin
                        dec_at = IDXW'(pos_m1);
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE_AT: begin
                if (empty) begin
                    dec_st = ST_EMPTY;
                end else if ((s_req_type == REQ_REMOVE_AT) && !pos_ok) begin
                    dec_st = ST_RANGE;
                end else begin
                    count_next = count_reg - CNTW'(1);
                    if (s_req_type != REQ_POP_BACK) begin
                        dec_ctrl.op = CELL_SHL;
                    end
                    if (s_req_type == REQ_REMOVE_AT) begin
                        dec_at = IDXW'(pos_m1);
                    end
                end
            end
            REQ_FIRST, REQ_LAST, REQ_READ_AT: begin
                if (empty) begin
                    dec_st = ST_EMPTY;
                end else if ((s_req_type == REQ_READ_AT) && !pos_ok) begin
                    dec_st = ST_RANGE;
                end else begin
                    dec_ctrl.rd = 1'b1;
                    if (s_req_type == REQ_LAST) begin
                        dec_rd = IDXW'(count_reg - CNTW'(1));
                    end else if (s_req_type == REQ_READ_AT) begin
                        dec_rd = IDXW'(pos_m1);
                    end
                end
            end
            REQ_SEARCH: begin
                if (empty) begin
                    dec_st = ST_EMPTY;
                end else begin
                    dec_ctrl.srch = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Advance the request sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_EXEC;
            S_EXEC:  state_next = S_FIN;
            S_FIN:   state_next = S_RESP;
            S_RESP:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state, count and decoded control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ctrl_reg  <= '{exec: 1'b0, op: CELL_HOLD, srch: 1'b0, rd: 1'b0};
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                count_reg <= count_next;
                ctrl_reg  <= dec_ctrl;
            end
        end
    end

    // Hold the item payload for the cells
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            at_reg    <= dec_at;
            rd_reg    <= dec_rd;
            st_reg    <= dec_st;
            value_reg <= s_value;
        end
    end

    // Let the cells move only in the execute cycle
    always_comb begin
        cell_ctrl      = ctrl_reg;
        cell_ctrl.exec = (state_reg == S_EXEC);
    end

    // Build the chain of cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign left_w[gi] = value_reg;
        end else begin : g_body
            assign left_w[gi] = entry_w[gi-1];
        end
        if (gi == DEPTH-1) begin : g_tail
            assign right_w[gi] = entry_w[gi];
        end else begin : g_link
            assign right_w[gi] = entry_w[gi+1];
        end

        bal_cell #(
            .DEPTH (DEPTH),
            .INDEX (gi)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .at_idx      (at_reg),
            .rd_idx      (rd_reg),
            .count       (count_reg),
            .value       (value_reg),
            .left_entry  (left_w[gi]),
            .right_entry (right_w[gi]),
            .entry       (entry_w[gi]),
            .tag         (tag_w[gi])
        );
    end

    // Collect the read word and the last matching position
    always_comb begin
        rd_or   = '0;
        found_w = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (tag_w[i]) begin
                rd_or   = rd_or | entry_w[i];
                found_w = CNTW'(i + 1);
            end
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN) begin
            m_status_reg         <= st_reg;
            m_read_value_reg     <= ctrl_reg.rd ? rd_or : '0;
            m_found_position_reg <= ctrl_reg.srch ? POS_W'(found_w) : '0;
            m_entry_count_reg    <= CNT_W'(count_reg);
        end
    end

    assign m_status         = m_status_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_found_position = m_found_position_reg;
    assign m_entry_count    = m_entry_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(DEPTH))
        else $error("list count beyond depth");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("item taken while a result waits");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_entry_count == CNT_W'(DEPTH)))
        else $error("full status with a list that is not full");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_found_position != '0)) |-> (m_status == ST_OK))
        else $error("match reported on a failed request");

    a_single_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FIN) && ctrl_reg.rd) |-> $onehot(tag_w))
        else $error("read did not select exactly one cell");

endmodule
